>>> hdl/mcle_pkg.sv
// shared types, constants and lookup tables for the morse color led encoder
package mcle_pkg;

    localparam int DUR_W    = 10;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_GAP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 8'd3;

    localparam logic [DUR_W-1:0] DOT_TIME_RST   = 10'd20;
    localparam logic [DUR_W-1:0] DASH_TIME_RST  = 10'd40;
    localparam logic [DUR_W-1:0] SYMBOL_GAP_RST = 10'd20;
    localparam logic [DUR_W-1:0] LETTER_GAP_RST = 10'd60;

    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_Z = 8'd90;

    localparam logic [2:0] COLOR_LAST = 3'd6;
    localparam logic [2:0] COLOR_BAD  = 3'd7;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [DUR_W-1:0] duration;
        logic             last;
    } seg_item_t;

    typedef struct packed {
        logic [DUR_W-1:0] dot_time;
        logic [DUR_W-1:0] dash_time;
        logic [DUR_W-1:0] symbol_gap;
        logic [DUR_W-1:0] letter_gap;
    } timing_t;

    // number of symbols in a letter, index 0 is A
    function automatic logic [2:0] sym_len_f(input logic [4:0] idx);
        logic [2:0] r;
        unique case (idx)
            5'd4, 5'd19:                                    r = 3'd1;
            5'd0, 5'd8, 5'd12, 5'd13:                       r = 3'd2;
            5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18, 5'd20,
            5'd22:                                          r = 3'd3;
            5'd1, 5'd2, 5'd5, 5'd7, 5'd9, 5'd11, 5'd15, 5'd16,
            5'd21, 5'd23, 5'd24, 5'd25:                     r = 3'd4;
            default:                                        r = 3'd0;
        endcase
        return r;
    endfunction

    // symbol bits, 1 is a dash, first symbol in the highest used bit
    function automatic logic [3:0] sym_bits_f(input logic [4:0] idx);
        logic [3:0] r;
        unique case (idx)
            5'd0:  r = 4'd1;
            5'd1:  r = 4'd8;
            5'd2:  r = 4'd10;
            5'd3:  r = 4'd4;
            5'd4:  r = 4'd0;
            5'd5:  r = 4'd2;
            5'd6:  r = 4'd6;
            5'd7:  r = 4'd0;
            5'd8:  r = 4'd0;
            5'd9:  r = 4'd7;
            5'd10: r = 4'd5;
            5'd11: r = 4'd4;
            5'd12: r = 4'd3;
            5'd13: r = 4'd2;
            5'd14: r = 4'd7;
            5'd15: r = 4'd6;
            5'd16: r = 4'd13;
            5'd17: r = 4'd2;
            5'd18: r = 4'd0;
            5'd19: r = 4'd1;
            5'd20: r = 4'd1;
            5'd21: r = 4'd1;
            5'd22: r = 4'd3;
            5'd23: r = 4'd9;
            5'd24: r = 4'd11;
            5'd25: r = 4'd12;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // rainbow color as {red, green, blue}
    function automatic logic [23:0] rainbow_f(input logic [2:0] pos);
        logic [23:0] r;
        unique case (pos)
            3'd0:    r = {8'd255, 8'd0,   8'd0};
            3'd1:    r = {8'd255, 8'd165, 8'd0};
            3'd2:    r = {8'd255, 8'd255, 8'd0};
            3'd3:    r = {8'd0,   8'd255, 8'd0};
            3'd4:    r = {8'd0,   8'd255, 8'd255};
            3'd5:    r = {8'd0,   8'd0,   8'd255};
            3'd6:    r = {8'd128, 8'd0,   8'd128};
            default: r = {8'd255, 8'd0,   8'd0};
        endcase
        return r;
    endfunction

endpackage

>>> hdl/morse_color_led_encoder.sv
// morse color led encoder top level: timing registers and output register
// each segment goes from the expander state registers into the output register
// one segment per cycle while seg_ready is high; a letter of n symbols gives
// 2n+1 segments, plus one for end of message; non-letters without the flag give none
// the next char is taken in the cycle the last segment of the current one moves out
// reset: timing registers return to 20/40/20/60 ms, color position to red
module morse_color_led_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  mcle_pkg::in_item_t             req_data,
    output logic                           seg_valid,
    input  logic                           seg_ready,
    output mcle_pkg::seg_item_t            seg_data,
    input  logic                           cfg_write,
    input  logic [mcle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcle_pkg::DUR_W-1:0]     cfg_data
);
    import mcle_pkg::*;

    timing_t   timing_reg;
    logic      seg_valid_reg, seg_valid_next;
    seg_item_t seg_reg;
    logic      load_ok;
    logic      emit;
    seg_item_t seg;

    mcle_expander u_expander (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .timing    (timing_reg),
        .load_ok   (load_ok),
        .emit      (emit),
        .seg       (seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.dot_time   <= DOT_TIME_RST;
            timing_reg.dash_time  <= DASH_TIME_RST;
            timing_reg.symbol_gap <= SYMBOL_GAP_RST;
            timing_reg.letter_gap <= LETTER_GAP_RST;
        end
        else if (cfg_write)
        begin
            // writes to unknown indexes are dropped
            if (cfg_index == REG_DOT_TIME)
                timing_reg.dot_time <= cfg_data;
            if (cfg_index == REG_DASH_TIME)
                timing_reg.dash_time <= cfg_data;
            if (cfg_index == REG_SYMBOL_GAP)
                timing_reg.symbol_gap <= cfg_data;
            if (cfg_index == REG_LETTER_GAP)
                timing_reg.letter_gap <= cfg_data;
        end
    end

    always_comb
    begin
        load_ok = !seg_valid_reg || seg_ready;
        if (emit)
            seg_valid_next = 1'b1;
        else if (seg_ready)
            seg_valid_next = 1'b0;
        else
            seg_valid_next = seg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_valid_reg <= 1'b0;
        else
            seg_valid_reg <= seg_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            seg_reg <= seg;
    end

    assign seg_valid = seg_valid_reg;
    assign seg_data  = seg_reg;

endmodule

>>> hdl/mcle_expander.sv
// holds one character and steps through its segments, one per cycle while load_ok is high
module mcle_expander (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mcle_pkg::in_item_t req_data,
    input  mcle_pkg::timing_t  timing,
    input  logic               load_ok,
    output logic               emit,
    output mcle_pkg::seg_item_t seg
);
    import mcle_pkg::*;

    logic       busy_reg, busy_next;
    logic       letter_reg, letter_next;
    logic [2:0] len_reg, len_next;
    logic [3:0] bits_reg, bits_next;
    logic [3:0] count_reg, count_next;
    logic [3:0] step_reg, step_next;
    logic [2:0] color_reg, color_next;

    logic       in_letter;
    logic [7:0] in_off;
    logic [2:0] in_len;
    logic [3:0] in_count;
    logic       is_sym;
    logic       is_lit;
    logic       is_lgap;
    logic       is_last;
    logic       dash;
    logic [2:0] sym_j;
    logic [2:0] sym_k;
    logic [2:0] pos;
    logic       accept;

    always_comb
    begin
        in_letter = (req_data.char_code >= CHAR_A) && (req_data.char_code <= CHAR_Z);
        in_off    = req_data.char_code - CHAR_A;
        in_len    = in_letter ? sym_len_f(in_off[4:0]) : 3'd0;
        // 2*len + 1 letter segments, plus the final off when end_of_message is set
        in_count  = (in_letter ? {in_len, 1'b1} : 4'd0)
                  + {3'd0, req_data.end_of_message};

        is_sym  = step_reg < {len_reg, 1'b0};
        is_lit  = is_sym && !step_reg[0];
        is_lgap = letter_reg && (step_reg == {len_reg, 1'b0});
        is_last = step_reg == (count_reg - 4'd1);
        sym_j   = step_reg[3:1];
        sym_k   = len_reg - 3'd1 - sym_j;
        dash    = bits_reg[sym_k[1:0]];
        pos     = (color_reg == COLOR_BAD) ? 3'd0 : color_reg;

        emit      = busy_reg && load_ok;
        req_ready = !busy_reg || (emit && is_last);
        accept    = req_valid && req_ready;

        seg.last = is_last;
        if (is_lit)
        begin
            {seg.red, seg.green, seg.blue} = rainbow_f(pos);
            seg.duration = dash ? timing.dash_time : timing.dot_time;
        end
        else
        begin
            {seg.red, seg.green, seg.blue} = 24'd0;
            if (is_sym)
                seg.duration = timing.symbol_gap;
            else if (is_lgap)
                seg.duration = timing.letter_gap;
            else
                seg.duration = '0;
        end

        busy_next   = busy_reg;
        letter_next = letter_reg;
        len_next    = len_reg;
        bits_next   = bits_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        color_next  = color_reg;

        if (emit)
        begin
            step_next = step_reg + 4'd1;
            if (is_lit)
                color_next = (pos == COLOR_LAST) ? 3'd0 : pos + 3'd1;
            else if (!is_sym && !is_lgap)
                color_next = 3'd0;
            if (is_last)
                busy_next = 1'b0;
        end

        if (accept)
        begin
            busy_next   = in_count != 4'd0;
            letter_next = in_letter;
            len_next    = in_len;
            bits_next   = sym_bits_f(in_off[4:0]);
            count_next  = in_count;
            step_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= 4'd0;
            color_reg <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            color_reg <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        len_reg    <= len_next;
        bits_reg   <= bits_next;
        count_reg  <= count_next;
    end

endmodule
